@@ rtl/core/lmmf_pkg.sv @@
// Shared constants for the label map majority filter.
package lmmf_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_NUM_LEVELS   = 2'd2;
   localparam logic [1:0] CSR_ZERO_BORDER  = 2'd3;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 16;
   localparam int NUM_LEVELS_BITS   = 4;
   localparam int IN_LABEL_BITS     = 4;
   localparam int OUT_COL_BITS      = 10;

   localparam int MIN_DIM = 3;

   // Reset values of the registers
   localparam int                       FRAME_WIDTH_RST  = 1024;
   localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 16'd480;
   localparam logic [NUM_LEVELS_BITS-1:0]   NUM_LEVELS_RST   = 4'd15;

   // Majority vote over the eight neighbors of the 3x3 window
   localparam int NUM_NBRS  = 8;
   localparam int MIN_COUNT = 6;
   localparam int CNT_BITS  = $clog2(NUM_NBRS + 1);
   // Any MIN_COUNT-of-NUM_NBRS winner shows up among this many neighbors
   localparam int NUM_CAND  = NUM_NBRS - MIN_COUNT + 1;

endpackage

@@ rtl/core/lmmf_line_store.sv @@
// Two line stores (upper and lower row) with registered reads.
module lmmf_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 4
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_upper,
   output logic [DW-1:0] rd_lower,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_upper,
   input  logic [DW-1:0] wr_lower
);

   logic [DW-1:0] upper_mem [DEPTH];
   logic [DW-1:0] lower_mem [DEPTH];
   logic [DW-1:0] rd_upper_ff;
   logic [DW-1:0] rd_lower_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_upper_ff <= upper_mem[rd_addr];
         rd_lower_ff <= lower_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr] <= wr_upper;
         lower_mem[wr_addr] <= wr_lower;
      end
   end

   assign rd_upper = rd_upper_ff;
   assign rd_lower = rd_lower_ff;

endmodule

@@ rtl/core/lmmf_vote.sv @@
// Majority vote over the eight neighbors of a 3x3 window.
module lmmf_vote #(
   parameter int LABEL_BITS = 4
) (
   input  logic [LABEL_BITS-1:0] nbr [lmmf_pkg::NUM_NBRS],
   output logic [LABEL_BITS-1:0] vote
);

   logic [lmmf_pkg::CNT_BITS-1:0] cnt [lmmf_pkg::NUM_CAND];

   // A label held by at least MIN_COUNT neighbors is unique and must sit
   // in one of the first NUM_CAND slots, so only those are counted.
   always_comb begin
      vote = '0;
      for (int k = 0; k < lmmf_pkg::NUM_CAND; k++) begin
         cnt[k] = '0;
         for (int j = 0; j < lmmf_pkg::NUM_NBRS; j++) begin
            cnt[k] = cnt[k] + lmmf_pkg::CNT_BITS'(nbr[j] == nbr[k]);
         end
         if (cnt[k] >= lmmf_pkg::CNT_BITS'(lmmf_pkg::MIN_COUNT)) begin
            vote = nbr[k];
         end
      end
   end

endmodule

@@ rtl/core/label_map_majority_filter.sv @@
// Top level of the label map majority filter (3x3 mode filter, one pass).
//
//  channel | dir | ports                                    | accept
//  --------+-----+------------------------------------------+---------------------
//  req     | in  | req_valid, req_stall, req_label          | valid && !stall
//  rsp     | out | rsp_valid, rsp_stall, rsp_row/col/       | valid && !stall
//          |     | label_res/last                           |
//  csr     | in  | csr_wen, csr_index, csr_wdata            | wen
//
// One word per cycle in while req_stall is low. A word's results reach rsp through
// the input register with line store read, the window stage and the result
// register. A word that makes two results (interior plus border) holds the
// window stage while the second result moves to the result register.
// Reset is synchronous; it clears the counters and valid flags and sets the
// configuration registers to their reset values; line stores and data registers
// keep their contents. A stall on rsp backs up through the stages to req_stall.
module label_map_majority_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int LABEL_BITS = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [lmmf_pkg::IN_LABEL_BITS-1:0]       req_label,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [lmmf_pkg::FRAME_HEIGHT_BITS-1:0]   rsp_row,
   output logic [lmmf_pkg::OUT_COL_BITS-1:0]        rsp_col,
   output logic [lmmf_pkg::IN_LABEL_BITS-1:0]       rsp_label_res,
   output logic                                     rsp_last,
   input  logic                                     csr_wen,
   input  logic [lmmf_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [lmmf_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RB       = lmmf_pkg::FRAME_HEIGHT_BITS;
   localparam int RST_W    = (MAX_WIDTH < lmmf_pkg::FRAME_WIDTH_RST) ?
                             MAX_WIDTH : lmmf_pkg::FRAME_WIDTH_RST;
   localparam logic [COL_BITS-1:0] COL_LAST_RST = COL_BITS'(RST_W - 1);

   // ---------------- configuration ----------------
   logic [COL_BITS-1:0]                    col_last_ff, col_last_in;
   logic [RB-1:0]                          row_last_ff, row_last_in;
   logic [lmmf_pkg::NUM_LEVELS_BITS-1:0]   num_levels_ff;
   logic                                   zero_border_ff;
   logic                                   geom_wr;
   logic [lmmf_pkg::FRAME_WIDTH_BITS-1:0]  fw;
   logic [RB-1:0]                          fh;

   assign fw      = csr_wdata[lmmf_pkg::FRAME_WIDTH_BITS-1:0];
   assign fh      = csr_wdata[RB-1:0];
   assign geom_wr = csr_wen && ((csr_index == lmmf_pkg::CSR_FRAME_WIDTH) ||
                                (csr_index == lmmf_pkg::CSR_FRAME_HEIGHT));

   always_comb begin
      int w_eff;
      w_eff = int'(fw);
      if (w_eff < lmmf_pkg::MIN_DIM) w_eff = lmmf_pkg::MIN_DIM;
      if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
      col_last_in = COL_BITS'(w_eff - 1);
      if (fh < RB'(lmmf_pkg::MIN_DIM)) row_last_in = RB'(lmmf_pkg::MIN_DIM - 1);
      else row_last_in = fh - RB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff    <= COL_LAST_RST;
         row_last_ff    <= lmmf_pkg::FRAME_HEIGHT_RST - RB'(1);
         num_levels_ff  <= lmmf_pkg::NUM_LEVELS_RST;
         zero_border_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            lmmf_pkg::CSR_FRAME_WIDTH:  col_last_ff    <= col_last_in;
            lmmf_pkg::CSR_FRAME_HEIGHT: row_last_ff    <= row_last_in;
            lmmf_pkg::CSR_NUM_LEVELS:
               num_levels_ff <= csr_wdata[lmmf_pkg::NUM_LEVELS_BITS-1:0];
            lmmf_pkg::CSR_ZERO_BORDER:  zero_border_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- raster counters and input register ----------------
   logic                  req_acc;
   logic                  adv1;
   logic                  s2_free;
   logic [COL_BITS-1:0]   col_ff;
   logic [RB-1:0]         row_ff;
   logic [LABEL_BITS-1:0] lab_mask, lab_clamp;

   logic                  v1_ff;
   logic [COL_BITS-1:0]   c1_ff;
   logic [RB-1:0]         r1_ff;
   logic [LABEL_BITS-1:0] lab1_ff;
   logic                  inner1_ff, border1_ff;
   logic [LABEL_BITS-1:0] top1, mid1;

   assign req_stall = v1_ff && !s2_free;
   assign req_acc   = req_valid && !req_stall;
   assign adv1      = v1_ff && s2_free;

   always_comb begin
      lab_mask = LABEL_BITS'(req_label);
      if (int'(lab_mask) > int'(num_levels_ff)) lab_clamp = LABEL_BITS'(num_levels_ff);
      else lab_clamp = lab_mask;
   end

   always_ff @(posedge clock) begin
      if (reset || geom_wr) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         if (col_ff == col_last_ff) begin
            col_ff <= '0;
            row_ff <= (row_ff == row_last_ff) ? '0 : row_ff + RB'(1);
         end else begin
            col_ff <= col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (req_acc) v1_ff <= 1'b1;
      else if (adv1) v1_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         c1_ff      <= col_ff;
         r1_ff      <= row_ff;
         lab1_ff    <= lab_clamp;
         inner1_ff  <= (row_ff >= RB'(2)) && (col_ff >= COL_BITS'(2));
         border1_ff <= (row_ff == '0) || (row_ff == row_last_ff) ||
                       (col_ff == '0) || (col_ff == col_last_ff);
      end
   end

   // Entry c is rewritten when its word leaves the input register; the next
   // read of the same column is at least three words later.
   lmmf_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_BITS),
      .DW    (LABEL_BITS)
   ) u_line (
      .clock    (clock),
      .rd_en    (req_acc),
      .rd_addr  (col_ff),
      .rd_upper (top1),
      .rd_lower (mid1),
      .wr_en    (adv1),
      .wr_addr  (c1_ff),
      .wr_upper (mid1),
      .wr_lower (lab1_ff)
   );

   // ---------------- window stage ----------------
   logic [LABEL_BITS-1:0] win_ff [3][3];   // [column oldest..newest][top, mid, bottom]
   logic [LABEL_BITS-1:0] nbr [lmmf_pkg::NUM_NBRS];
   logic [LABEL_BITS-1:0] vote;

   logic                  v2_ff, inner2_ff, border2_ff;
   logic [COL_BITS-1:0]   c2_ff;
   logic [RB-1:0]         r2_ff;
   logic [LABEL_BITS-1:0] lab2_ff;
   logic                  out_free, emit, both2;

   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[0][i] <= win_ff[1][i];
            win_ff[1][i] <= win_ff[2][i];
         end
         win_ff[2][0] <= top1;
         win_ff[2][1] <= mid1;
         win_ff[2][2] <= lab1_ff;
         c2_ff        <= c1_ff;
         r2_ff        <= r1_ff;
         lab2_ff      <= lab1_ff;
      end
   end

   assign nbr[0] = win_ff[0][0];
   assign nbr[1] = win_ff[0][1];
   assign nbr[2] = win_ff[0][2];
   assign nbr[3] = win_ff[1][0];
   assign nbr[4] = win_ff[1][2];
   assign nbr[5] = win_ff[2][0];
   assign nbr[6] = win_ff[2][1];
   assign nbr[7] = win_ff[2][2];

   lmmf_vote #(.LABEL_BITS(LABEL_BITS)) u_vote (
      .nbr  (nbr),
      .vote (vote)
   );

   assign out_free = !rsp_valid || !rsp_stall;
   assign both2    = inner2_ff && border2_ff;
   assign emit     = v2_ff && (inner2_ff || border2_ff) && out_free;
   assign s2_free  = !v2_ff || !(inner2_ff || border2_ff) || (out_free && !both2);

   // Interior result goes first; border result follows from the same word.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff      <= 1'b0;
         inner2_ff  <= 1'b0;
         border2_ff <= 1'b0;
      end else if (adv1) begin
         v2_ff      <= 1'b1;
         inner2_ff  <= inner1_ff;
         border2_ff <= border1_ff;
      end else if (s2_free) begin
         v2_ff <= 1'b0;
      end else if (emit) begin
         inner2_ff <= 1'b0;
      end
   end

   // ---------------- result register ----------------
   logic                                     rsp_valid_ff;
   logic [RB-1:0]                            rsp_row_ff, rsp_row_in;
   logic [lmmf_pkg::OUT_COL_BITS-1:0]        rsp_col_ff, rsp_col_in;
   logic [lmmf_pkg::IN_LABEL_BITS-1:0]       rsp_lab_ff, rsp_lab_in;
   logic                                     rsp_last_ff, rsp_last_in;

   always_comb begin
      if (inner2_ff) begin
         rsp_row_in  = r2_ff - RB'(1);
         rsp_col_in  = lmmf_pkg::OUT_COL_BITS'(COL_BITS'(c2_ff - COL_BITS'(1)));
         rsp_lab_in  = lmmf_pkg::IN_LABEL_BITS'(vote);
         rsp_last_in = !border2_ff;
      end else begin
         rsp_row_in  = r2_ff;
         rsp_col_in  = lmmf_pkg::OUT_COL_BITS'(c2_ff);
         rsp_lab_in  = zero_border_ff ? '0 : lmmf_pkg::IN_LABEL_BITS'(lab2_ff);
         rsp_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_free) rsp_valid_ff <= emit;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff  <= rsp_row_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_lab_ff  <= rsp_lab_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_col       = rsp_col_ff;
   assign rsp_label_res = rsp_lab_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

@@ rtl/core/lmmf_checker.sv @@
// Port-level checks for the label map majority filter, bound to the top level.
module lmmf_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [lmmf_pkg::FRAME_HEIGHT_BITS-1:0] rsp_row,
   input logic [lmmf_pkg::OUT_COL_BITS-1:0]      rsp_col,
   input logic [lmmf_pkg::IN_LABEL_BITS-1:0]     rsp_label_res,
   input logic                                   rsp_last
);

   // Reset empties the pipe.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

   // A stalled word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row) && $stable(rsp_col)
                                 && $stable(rsp_label_res) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // A non-final word is an interior pixel and never sits on row 0 or column 0.
   a_inner_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_row != '0) && (rsp_col != '0))
      else $error("interior result on first row or column");

   // The border word follows its interior word at once, one row and column on.
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_last &&
         (rsp_row == $past(rsp_row) + 16'd1) &&
         (rsp_col == $past(rsp_col) + 10'd1))
      else $error("border word missing after interior word");

endmodule

bind label_map_majority_filter lmmf_checker u_lmmf_checker (.*);
